@@ hw/rtl/u8d_pkg.sv @@
// Shared types, constants and helper functions for the UTF-8 stream decoder.
// No dependencies; imported by every module of the decoder.
`default_nettype none

package u8d_pkg;

    localparam longint unsigned COUNT_MAX = 65535;
    localparam int COUNT_W = 16;
    localparam int CP_W = 32;
    localparam int LEN_W = 3;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT =
        (COUNT_MAX > 64'd65535) ? {COUNT_W{1'b1}} : COUNT_W'(COUNT_MAX);

    localparam logic [7:0] LEAD6_MASK   = 8'hFC;
    localparam logic [7:0] LEAD5_MASK   = 8'hF8;
    localparam logic [7:0] LEAD4_MASK   = 8'hF0;
    localparam logic [7:0] LEAD3_MASK   = 8'hE0;
    localparam logic [7:0] LEAD2_MASK   = 8'hC0;
    localparam logic [5:0] CONT_PAYLOAD = 6'h3F;
    localparam logic [1:0] CONT_TAG     = 2'h2;
    localparam logic [7:0] BYTE_MASK    = 8'hFF;

    localparam logic [LEN_W-1:0] LEN_STRAY  = 3'd0;
    localparam logic [LEN_W-1:0] LEN_SINGLE = 3'd1;

    typedef struct packed {
        logic [CP_W-1:0]    code_point;
        logic               char_done;
        logic               byte_error;
        logic               string_end;
        logic               string_valid;
        logic [COUNT_W-1:0] char_count;
        logic [COUNT_W-1:0] byte_count;
    } result_t;

    function automatic logic [LEN_W-1:0] lead_length(input logic [7:0] b);
        logic [LEN_W-1:0] len;
        if (!b[7])                            len = 3'd1;
        else if ((b & LEAD6_MASK) == LEAD6_MASK) len = 3'd6;
        else if ((b & LEAD5_MASK) == LEAD5_MASK) len = 3'd5;
        else if ((b & LEAD4_MASK) == LEAD4_MASK) len = 3'd4;
        else if ((b & LEAD3_MASK) == LEAD3_MASK) len = 3'd3;
        else if ((b & LEAD2_MASK) == LEAD2_MASK) len = 3'd2;
        else                                  len = LEN_STRAY;
        return len;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_add(
        input logic [COUNT_W-1:0] v,
        input logic [LEN_W-1:0]   n
    );
        logic [COUNT_W:0] s;
        s = {1'b0, v} + {{(COUNT_W-LEN_W+1){1'b0}}, n};
        return (s > {1'b0, COUNT_LIMIT}) ? COUNT_LIMIT : s[COUNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/u8d_core.sv @@
// Decoder state registers and the per-byte decode logic.
// Depends on u8d_pkg; advances one byte per cycle when advance is high.
`default_nettype none

module u8d_core (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             advance,
    input  wire logic [7:0]       data_byte,
    input  wire logic             end_of_string,
    output u8d_pkg::result_t      result
);
    import u8d_pkg::*;

    logic [LEN_W-1:0]   rem_reg, rem_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [CP_W-1:0]    partial_reg, partial_next;
    logic               invalid_reg, invalid_next;
    logic [COUNT_W-1:0] chars_reg, chars_next;
    logic [COUNT_W-1:0] bytes_reg, bytes_next;

    logic [LEN_W-1:0]   lead_len;
    logic [LEN_W-1:0]   rem_dec;
    logic [CP_W-1:0]    shifted;
    logic [CP_W-1:0]    cp;
    logic               done;
    logic               err;

    always_comb begin
        rem_next     = rem_reg;
        len_next     = len_reg;
        partial_next = partial_reg;
        chars_next   = chars_reg;
        bytes_next   = bytes_reg;
        cp           = '0;
        done         = 1'b0;
        err          = 1'b0;
        lead_len     = lead_length(data_byte);
        rem_dec      = rem_reg - 3'd1;
        shifted      = {partial_reg[CP_W-7:0], data_byte[5:0] & CONT_PAYLOAD};

        if (rem_reg == '0) begin
            if (lead_len == LEN_STRAY) begin
                err = 1'b1;
            end else if (lead_len == LEN_SINGLE) begin
                cp         = {{(CP_W-8){1'b0}}, data_byte};
                done       = 1'b1;
                chars_next = sat_add(chars_reg, 3'd1);
                bytes_next = sat_add(bytes_reg, 3'd1);
            end else begin
                partial_next = {{(CP_W-8){1'b0}}, data_byte & (BYTE_MASK >> lead_len)};
                rem_next     = lead_len - 3'd1;
                len_next     = lead_len;
            end
        end else if (data_byte[7:6] == CONT_TAG) begin
            partial_next = shifted;
            rem_next     = rem_dec;
            if (rem_dec == '0) begin
                cp           = shifted;
                done         = 1'b1;
                chars_next   = sat_add(chars_reg, 3'd1);
                bytes_next   = sat_add(bytes_reg, len_reg);
                partial_next = '0;
                len_next     = '0;
            end
        end else begin
            err          = 1'b1;
            rem_next     = '0;
            partial_next = '0;
            len_next     = '0;
        end

        if (end_of_string && rem_next != '0) begin
            err = 1'b1;
        end
        invalid_next = invalid_reg | err;

        result.code_point   = cp;
        result.char_done    = done;
        result.byte_error   = err;
        result.string_end   = end_of_string;
        result.string_valid = end_of_string & ~invalid_next;
        result.char_count   = chars_next;
        result.byte_count   = bytes_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg     <= '0;
            len_reg     <= '0;
            partial_reg <= '0;
            invalid_reg <= 1'b0;
            chars_reg   <= '0;
            bytes_reg   <= '0;
        end else if (advance) begin
            if (end_of_string) begin
                rem_reg     <= '0;
                len_reg     <= '0;
                partial_reg <= '0;
                invalid_reg <= 1'b0;
                chars_reg   <= '0;
                bytes_reg   <= '0;
            end else begin
                rem_reg     <= rem_next;
                len_reg     <= len_next;
                partial_reg <= partial_next;
                invalid_reg <= invalid_next;
                chars_reg   <= chars_next;
                bytes_reg   <= bytes_next;
            end
        end
    end

    ap_len_matches_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (rem_reg != '0) |-> (len_reg > rem_reg))
        else $error("sequence length not above remaining count");

    ap_idle_partial_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (rem_reg == '0) |-> (partial_reg == '0 && len_reg == '0))
        else $error("partial state left over between sequences");

    ap_counts_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (chars_reg <= COUNT_LIMIT) && (bytes_reg <= COUNT_LIMIT))
        else $error("count above saturation limit");

endmodule

`default_nettype wire

@@ hw/rtl/utf8_stream_decoder_unit.sv @@
// UTF-8 stream decoder top level: input register, decode core, result register.
// Path: a byte is held in the input register, decoded by the core and shown from the result register.
// Throughput: one byte per cycle while the output is taken; the result register frees as the input stage moves.
// Reset (aresetn low, synchronous) empties both stages and clears the decoder state.
// Depends on u8d_pkg and u8d_core.
`default_nettype none

module utf8_stream_decoder_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [7:0]                    s_data_byte,
    input  wire logic                          s_end_of_string,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [u8d_pkg::CP_W-1:0]           m_code_point,
    output logic                               m_char_done,
    output logic                               m_byte_error,
    output logic                               m_string_end,
    output logic                               m_string_valid,
    output logic [u8d_pkg::COUNT_W-1:0]        m_char_count,
    output logic [u8d_pkg::COUNT_W-1:0]        m_byte_count
);
    import u8d_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eos_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    core_result;
    logic       advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    u8d_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .data_byte     (in_byte_reg),
        .end_of_string (in_eos_reg),
        .result        (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_byte_reg <= s_data_byte;
            in_eos_reg  <= s_end_of_string;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_reg <= core_result;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_code_point   = out_reg.code_point;
    assign m_char_done    = out_reg.char_done;
    assign m_byte_error   = out_reg.byte_error;
    assign m_string_end   = out_reg.string_end;
    assign m_string_valid = out_reg.string_valid;
    assign m_char_count   = out_reg.char_count;
    assign m_byte_count   = out_reg.byte_count;

    ap_done_xor_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_char_done && m_byte_error))
        else $error("character completed and flagged as error together");

    ap_valid_needs_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_string_valid) |-> (m_string_end && !m_byte_error))
        else $error("string_valid outside a clean string end");

    ap_cp_only_when_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_char_done) |-> (m_code_point == '0))
        else $error("code point shown without a completed character");

    ap_empty_takes_input: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("empty input stage refuses an item");

endmodule

`default_nettype wire

@@ tb/tb_utf8_stream_decoder_unit.sv @@
// Self-checking testbench for utf8_stream_decoder_unit: byte strings in, decoded characters out.
// A built-in decoder predicts each result, and a clocked monitor compares it field by field.
// Depends on u8d_pkg and the decoder RTL.
module tb_utf8_stream_decoder_unit;

    import u8d_pkg::*;

    typedef struct {
        bit [7:0]    data;
        bit          eos;
        bit          drain;
        int unsigned s_idle;
        int unsigned m_idle;
    } byte_req_t;

    typedef enum int {
        FAULT_NONE,
        FAULT_STRAY,
        FAULT_TRUNCATE,
        FAULT_NOISE,
        FAULT_OPEN_END
    } fault_kind_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [7:0]          s_data_byte = 8'h00;
    logic                s_end_of_string = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [CP_W-1:0]     m_code_point;
    logic                m_char_done;
    logic                m_byte_error;
    logic                m_string_end;
    logic                m_string_valid;
    logic [COUNT_W-1:0]  m_char_count;
    logic [COUNT_W-1:0]  m_byte_count;

    byte_req_t   pending_bytes[$];
    result_t     decoded_expect[$];
    bit          byte_taken = 1'b0;
    int unsigned recv_idle_pct = 85;
    int unsigned cur_s_idle = 36;
    int unsigned cur_m_idle = 85;
    bit          drain_next = 1'b0;
    int unsigned bytes_queued = 0;
    int unsigned mismatch_count = 0;

    logic [2:0]          dec_remaining = '0;
    logic [31:0]         dec_partial = '0;
    logic                dec_invalid = 1'b0;
    logic [COUNT_W-1:0]  dec_chars = '0;
    logic [COUNT_W-1:0]  dec_bytes = '0;
    logic [2:0]          dec_seq_len = '0;

    utf8_stream_decoder_unit DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_end_of_string (s_end_of_string),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_code_point    (m_code_point),
        .m_char_done     (m_char_done),
        .m_byte_error    (m_byte_error),
        .m_string_end    (m_string_end),
        .m_string_valid  (m_string_valid),
        .m_char_count    (m_char_count),
        .m_byte_count    (m_byte_count)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [2:0] lead_len_of(input logic [7:0] b);
        logic [2:0] len;
        casez (b)
            8'b0???????: len = 3'd1;
            8'b111111??: len = 3'd6;
            8'b11111???: len = 3'd5;
            8'b1111????: len = 3'd4;
            8'b111?????: len = 3'd3;
            8'b11??????: len = 3'd2;
            default:     len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [COUNT_W-1:0] count_sat(
        input logic [COUNT_W-1:0] v,
        input logic [2:0]         n
    );
        logic [COUNT_W:0] s;
        s = {1'b0, v} + {{(COUNT_W-2){1'b0}}, n};
        return (s > {1'b0, COUNT_LIMIT}) ? COUNT_LIMIT : s[COUNT_W-1:0];
    endfunction

    task automatic predict_decode(input logic [7:0] b, input logic eos);
        result_t    r;
        logic [2:0] len;
        r = '0;
        if (dec_remaining == 3'd0) begin
            len = lead_len_of(b);
            if (len == 3'd0) begin
                r.byte_error = 1'b1;
            end else if (len == 3'd1) begin
                r.code_point = {24'd0, b};
                r.char_done = 1'b1;
                dec_chars = count_sat(dec_chars, 3'd1);
                dec_bytes = count_sat(dec_bytes, 3'd1);
            end else begin
                dec_partial = {24'd0, b & (8'hFF >> len)};
                dec_remaining = len - 3'd1;
                dec_seq_len = len;
            end
        end else if (b[7:6] == 2'b10) begin
            dec_partial = {dec_partial[25:0], b[5:0]};
            dec_remaining = dec_remaining - 3'd1;
            if (dec_remaining == 3'd0) begin
                r.code_point = dec_partial;
                r.char_done = 1'b1;
                dec_chars = count_sat(dec_chars, 3'd1);
                dec_bytes = count_sat(dec_bytes, dec_seq_len);
                dec_partial = '0;
                dec_seq_len = '0;
            end
        end else begin
            r.byte_error = 1'b1;
            dec_remaining = '0;
            dec_partial = '0;
            dec_seq_len = '0;
        end
        if (eos && dec_remaining != 3'd0)
            r.byte_error = 1'b1;
        if (r.byte_error)
            dec_invalid = 1'b1;
        r.string_end = eos;
        r.string_valid = eos && !dec_invalid;
        r.char_count = dec_chars;
        r.byte_count = dec_bytes;
        decoded_expect.insert(decoded_expect.size(), r);
        if (eos) begin
            dec_remaining = '0;
            dec_partial = '0;
            dec_invalid = 1'b0;
            dec_chars = '0;
            dec_bytes = '0;
            dec_seq_len = '0;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %h got %h", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        result_t r;
        byte_taken <= s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready)
                predict_decode(s_data_byte, s_end_of_string);
            if (m_valid && m_ready) begin
                if (decoded_expect.size() == 0) begin
                    $display("%0t: unexpected item, expected none got code_point %h",
                             $time, m_code_point);
                    mismatch_count++;
                end else begin
                    r = decoded_expect.pop_front();
                    check_field("code_point", r.code_point, m_code_point);
                    check_field("char_done", 32'(r.char_done), 32'(m_char_done));
                    check_field("byte_error", 32'(r.byte_error), 32'(m_byte_error));
                    check_field("string_end", 32'(r.string_end), 32'(m_string_end));
                    check_field("string_valid", 32'(r.string_valid),
                                32'(m_string_valid));
                    check_field("char_count", 32'(r.char_count), 32'(m_char_count));
                    check_field("byte_count", 32'(r.byte_count), 32'(m_byte_count));
                end
            end
        end
    end

    always @(negedge aclk) begin
        byte_req_t nxt;
        bit        present;
        if (aresetn) begin
            present = s_valid && !byte_taken;
            if (!present && pending_bytes.size() > 0) begin
                nxt = pending_bytes[0];
                recv_idle_pct = nxt.m_idle;
                if ((!nxt.drain || decoded_expect.size() == 0) &&
                    $urandom_range(0, 99) >= nxt.s_idle) begin
                    void'(pending_bytes.pop_front());
                    s_data_byte <= nxt.data;
                    s_end_of_string <= nxt.eos;
                    present = 1'b1;
                end
            end
            s_valid <= present;
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic push_byte(input bit [7:0] b, input bit eos);
        byte_req_t req;
        req.data = b;
        req.eos = eos;
        req.drain = drain_next;
        req.s_idle = cur_s_idle;
        req.m_idle = cur_m_idle;
        drain_next = 1'b0;
        pending_bytes.insert(pending_bytes.size(), req);
        bytes_queued++;
    endtask

    task automatic push_string(input bit [7:0] q[$], input bit eos_last);
        for (int i = 0; i < q.size(); i++)
            push_byte(q[i], eos_last && (i == q.size() - 1));
    endtask

    task automatic append_char(ref bit [7:0] q[$], input int len);
        case (len)
            1: q.insert(q.size(), 8'($urandom_range(0, 127)));
            2: q.insert(q.size(), 8'hC0 | 8'($urandom & 32'h1F));
            3: q.insert(q.size(), 8'hE0 | 8'($urandom & 32'h0F));
            4: q.insert(q.size(), 8'hF0 | 8'($urandom & 32'h07));
            5: q.insert(q.size(), 8'hF8 | 8'($urandom & 32'h03));
            default: q.insert(q.size(), 8'hFC | 8'($urandom & 32'h03));
        endcase
        for (int i = 1; i < len; i++)
            q.insert(q.size(), 8'h80 | 8'($urandom & 32'h3F));
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return 1;
        if (r < 60) return 2;
        if (r < 78) return 3;
        if (r < 90) return 4;
        if (r < 95) return 5;
        return 6;
    endfunction

    task automatic gen_string();
        bit [7:0]    q[$];
        int          nchar;
        int          len;
        int          open_len;
        fault_kind_t fault;
        nchar = $urandom_range(1, 10);
        fault = FAULT_NONE;
        if ($urandom_range(0, 99) < 25)
            fault = fault_kind_t'($urandom_range(1, 4));
        for (int c = 0; c < nchar; c++) begin
            len = pick_len();
            append_char(q, len);
            if (fault == FAULT_STRAY && $urandom_range(0, 3) == 0)
                q.insert(q.size(), 8'h80 | 8'($urandom & 32'h3F));
            if (fault == FAULT_TRUNCATE && len > 1 && $urandom_range(0, 2) == 0)
                void'(q.pop_back());
            if (fault == FAULT_NOISE && $urandom_range(0, 2) == 0)
                q.insert(q.size(), 8'($urandom_range(0, 255)));
        end
        if (fault == FAULT_OPEN_END) begin
            open_len = $urandom_range(2, 6);
            append_char(q, open_len);
            for (int i = $urandom_range(1, open_len - 1); i > 0; i--)
                void'(q.pop_back());
        end
        push_string(q, 1'b1);
    endtask

    initial begin
        bit [7:0] q[$];
        // well-formed 1 to 3 byte characters, zero byte included, then a 4 byte one cut short at the string end
        q = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hE2, 8'h82, 8'hAC, 8'hF4, 8'h8F, 8'hBF};
        push_string(q, 1'b1);
        q = '{8'hBF};
        push_string(q, 1'b1);
        q = '{8'hF8, 8'h88, 8'h80, 8'h80, 8'h80, 8'hFF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF};
        push_string(q, 1'b1);
        q = '{8'hC3, 8'h41};
        push_string(q, 1'b1);
        q = '{8'hE2, 8'h82};
        push_string(q, 1'b1);

        while (bytes_queued < 450)
            gen_string();

        cur_s_idle = 85;
        cur_m_idle = 36;
        drain_next = 1'b1;
        while (bytes_queued < 880)
            gen_string();

        cur_s_idle = 0;
        cur_m_idle = 0;
        drain_next = 1'b1;
        while (bytes_queued < 1300)
            gen_string();

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_bytes.size() != 0 || s_valid || decoded_expect.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && decoded_expect.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("%0t: timeout", $time);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
